// ----- hw/rtl/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes for the Go-Back-N sender window block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int CNT_W      = 6;

    // input operation codes
    localparam logic [1:0] OP_QUEUE   = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // timer commands
    localparam logic [1:0] TMR_NONE    = 2'd0;
    localparam logic [1:0] TMR_START   = 2'd1;
    localparam logic [1:0] TMR_RESTART = 2'd2;
    localparam logic [1:0] TMR_STOP    = 2'd3;

    localparam logic [5:0] WIN_RESET = 6'd10;

    typedef struct packed {
        logic capture;
        logic decide;
        logic count;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_stat;

endpackage

// ----- hw/rtl/gbn_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: capture a word, decide, count the sends, then emit results.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  gbn_pkg::t_dp_stat  i_stat,
    output logic               o_stall,
    output gbn_pkg::t_dp_cmd   o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_COUNT  = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_COUNT;
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/gbn_dp.sv -----
// ----------------------------------------------------------------------------
// gbn_dp
// Window state, sequence arithmetic, send counter and output register.
// ----------------------------------------------------------------------------
module gbn_dp #(
    parameter int SEQ_SPACE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gbn_pkg::t_dp_cmd  i_cmd,
    output gbn_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_ack_number,
    input  logic              i_ack_intact,
    input  logic              i_window_size_we,
    input  logic [5:0]        i_window_size_wdata,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_send_valid,
    output logic [7:0]        o_send_sequence,
    output logic              o_is_retransmission,
    output logic [1:0]        o_timer_action,
    output logic              o_ack_accepted,
    output logic              o_space_full_error,
    output logic              o_last_result
);

    localparam int SW      = $clog2(SEQ_SPACE);
    localparam int CW      = ((SW > 8) ? SW : 8) + 1;
    localparam int WIN_CAP = ((SEQ_SPACE - 1) < gbn_pkg::MAX_WINDOW) ?
                             (SEQ_SPACE - 1) : gbn_pkg::MAX_WINDOW;
    localparam int CNT_W   = gbn_pkg::CNT_W;

    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_SEND   = 2'd1;
    localparam logic [1:0] MODE_RESEND = 2'd2;

    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] a);
        return (a == SW'(SEQ_SPACE - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [SW-1:0] seq_dist(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic [SW:0] t;
        if (a >= b) begin
            t = {1'b0, a} - {1'b0, b};
        end else begin
            t = {1'b0, a} + (SW+1)'(SEQ_SPACE) - {1'b0, b};
        end
        return t[SW-1:0];
    endfunction

    // window state
    logic [SW-1:0]    r_base;
    logic [SW-1:0]    r_free;
    logic [SW-1:0]    r_unsent;
    logic             r_timer_run;
    logic [5:0]       r_window;

    // captured word and per-item flags
    logic [1:0]       r_op;
    logic [7:0]       r_ack;
    logic             r_intact;
    logic [1:0]       r_mode;
    logic             r_acc;
    logic             r_err;
    logic [1:0]       r_tmr;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_ptr;

    // output register
    logic             r_out_valid;
    logic             r_o_send_valid;
    logic [7:0]       r_o_seq;
    logic             r_o_retx;
    logic [1:0]       r_o_tmr;
    logic             r_o_acc;
    logic             r_o_err;
    logic             r_o_last;

    // effective window
    logic [5:0] win_clamp;
    logic [5:0] win_eff;

    always_comb begin
        if (r_window == 6'd0) begin
            win_clamp = 6'd1;
        end else if (r_window > 6'(gbn_pkg::MAX_WINDOW)) begin
            win_clamp = 6'(gbn_pkg::MAX_WINDOW);
        end else begin
            win_clamp = r_window;
        end
        win_eff = (win_clamp > 6'(WIN_CAP)) ? 6'(WIN_CAP) : win_clamp;
    end

    // decide terms
    logic [SW-1:0] ack_seq;
    logic [SW-1:0] held;
    logic [SW-1:0] flight;
    logic [SW-1:0] ack_dist;
    logic          ack_big;
    logic          space_full;
    logic          ack_ok;

    assign ack_seq    = SW'(r_ack);
    assign held       = seq_dist(r_free, r_base);
    assign flight     = seq_dist(r_unsent, r_base);
    assign ack_dist   = seq_dist(ack_seq, r_base);
    assign ack_big    = CW'(r_ack) >= CW'(SEQ_SPACE);
    assign space_full = CW'(held) >= CW'(SEQ_SPACE - 1);
    assign ack_ok     = !ack_big && (ack_dist != '0) && (CW'(ack_dist) <= CW'(flight));

    // count terms
    logic [SW-1:0]    queued;
    logic [CW-1:0]    room;
    logic [CW-1:0]    cnt_send;
    logic [CW-1:0]    cnt_resend;
    logic [CNT_W-1:0] cnt_next;

    assign queued = seq_dist(r_free, r_unsent);

    always_comb begin
        room = (CW'(win_eff) > CW'(flight)) ? CW'(win_eff) - CW'(flight) : '0;
        cnt_send   = (CW'(queued) < room) ? CW'(queued) : room;
        cnt_resend = (CW'(flight) < CW'(gbn_pkg::MAX_WINDOW)) ?
                     CW'(flight) : CW'(gbn_pkg::MAX_WINDOW);
        case (r_mode)
            MODE_SEND:   cnt_next = CNT_W'(cnt_send);
            MODE_RESEND: cnt_next = CNT_W'(cnt_resend);
            default:     cnt_next = '0;
        endcase
    end

    // result in flight to the output register
    logic emit_blank;
    logic emit_last;

    assign emit_blank = (r_cnt == '0);
    assign emit_last  = (r_cnt <= CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= SW'(1);
            r_free      <= SW'(1);
            r_unsent    <= SW'(1);
            r_timer_run <= 1'b0;
            r_window    <= gbn_pkg::WIN_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_window_size_we) begin
                r_window <= i_window_size_wdata;
            end

            if (i_cmd.decide) begin
                case (r_op)
                    gbn_pkg::OP_QUEUE: begin
                        if (!space_full) begin
                            r_free      <= seq_inc(r_free);
                            r_timer_run <= 1'b1;
                        end
                    end
                    gbn_pkg::OP_ACK: begin
                        if (!r_intact) begin
                            r_timer_run <= 1'b1;
                        end else if (ack_ok) begin
                            r_base      <= ack_seq;
                            r_timer_run <= (r_free != ack_seq);
                        end
                    end
                    gbn_pkg::OP_TIMEOUT: begin
                        r_timer_run <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.count) begin
                r_cnt <= cnt_next;
            end

            if (i_cmd.emit) begin
                if (!emit_blank) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_mode == MODE_SEND) begin
                        r_unsent <= seq_inc(r_ptr);
                    end
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_ack    <= i_ack_number;
            r_intact <= i_ack_intact;
        end

        if (i_cmd.decide) begin
            r_mode <= MODE_SINGLE;
            r_acc  <= 1'b0;
            r_err  <= 1'b0;
            r_tmr  <= gbn_pkg::TMR_NONE;
            case (r_op)
                gbn_pkg::OP_QUEUE: begin
                    if (space_full) begin
                        r_err <= 1'b1;
                    end else begin
                        r_mode <= MODE_SEND;
                        r_tmr  <= r_timer_run ? gbn_pkg::TMR_NONE : gbn_pkg::TMR_START;
                    end
                end
                gbn_pkg::OP_ACK: begin
                    if (!r_intact) begin
                        r_tmr <= r_timer_run ? gbn_pkg::TMR_NONE : gbn_pkg::TMR_START;
                    end else if (ack_ok) begin
                        r_mode <= MODE_SEND;
                        r_acc  <= 1'b1;
                        r_tmr  <= (r_free != ack_seq) ? gbn_pkg::TMR_RESTART
                                                      : gbn_pkg::TMR_STOP;
                    end
                end
                gbn_pkg::OP_TIMEOUT: begin
                    r_mode <= MODE_RESEND;
                    r_tmr  <= gbn_pkg::TMR_START;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.count) begin
            r_ptr <= (r_mode == MODE_SEND) ? r_unsent : r_base;
        end

        if (i_cmd.emit) begin
            r_o_acc  <= r_acc;
            r_o_last <= emit_last;
            r_o_tmr  <= emit_last ? r_tmr : gbn_pkg::TMR_NONE;
            if (emit_blank) begin
                r_o_send_valid <= 1'b0;
                r_o_seq        <= 8'd0;
                r_o_retx       <= 1'b0;
                r_o_err        <= r_err;
            end else begin
                r_o_send_valid <= 1'b1;
                r_o_seq        <= 8'(r_ptr);
                r_o_retx       <= (r_mode == MODE_RESEND);
                r_o_err        <= 1'b0;
                r_ptr          <= seq_inc(r_ptr);
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_stat.last     = emit_last;

    assign o_valid             = r_out_valid;
    assign o_send_valid        = r_o_send_valid;
    assign o_send_sequence     = r_o_seq;
    assign o_is_retransmission = r_o_retx;
    assign o_timer_action      = r_o_tmr;
    assign o_ack_accepted      = r_o_acc;
    assign o_space_full_error  = r_o_err;
    assign o_last_result       = r_o_last;

endmodule

// ----- hw/rtl/go_back_n_sender_window.sv -----
// Path: the accepting edge captures a word, which then passes the decide and
//   count states before its first result is loaded into the output register.
// Results: n = 1..32 per word, one result per cycle from the send counter
//   while the output is not stalled; o_stall holds off new words until then.
// Reset: synchronous, active low; base, next free and next unsent go to 1,
//   timer stopped, window 10. No clearing pass.
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-Back-N sender window control: queue, cumulative ack and timeout handling.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
    parameter int SEQ_SPACE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_ack_number,
    input  logic       i_ack_intact,
    input  logic       i_window_size_we,
    input  logic [5:0] i_window_size_wdata,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_send_valid,
    output logic [7:0] o_send_sequence,
    output logic       o_is_retransmission,
    output logic [1:0] o_timer_action,
    output logic       o_ack_accepted,
    output logic       o_space_full_error,
    output logic       o_last_result
);

    gbn_pkg::t_dp_cmd  cmd;
    gbn_pkg::t_dp_stat stat;

    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    gbn_dp #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_operation         (i_operation),
        .i_ack_number        (i_ack_number),
        .i_ack_intact        (i_ack_intact),
        .i_window_size_we    (i_window_size_we),
        .i_window_size_wdata (i_window_size_wdata),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_send_valid        (o_send_valid),
        .o_send_sequence     (o_send_sequence),
        .o_is_retransmission (o_is_retransmission),
        .o_timer_action      (o_timer_action),
        .o_ack_accepted      (o_ack_accepted),
        .o_space_full_error  (o_space_full_error),
        .o_last_result       (o_last_result)
    );

endmodule

// ----- hw/rtl/gbn_checker.sv -----
// ----------------------------------------------------------------------------
// gbn_checker
// Port-level checks on the result channel of the sender window block.
// ----------------------------------------------------------------------------
module gbn_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_send_valid,
    input logic [7:0] o_send_sequence,
    input logic [1:0] o_timer_action,
    input logic       o_space_full_error,
    input logic       o_last_result
);

    // hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_send_sequence))
        else $error("stalled result word changed");

    // timer command only on the closing result
    a_timer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |-> o_timer_action == gbn_pkg::TMR_NONE)
        else $error("timer command before last result");

    // a dropped packet is one result with no send
    a_full_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_space_full_error |-> !o_send_valid && o_last_result)
        else $error("space full error with a send or not last");

    // an empty result closes its word and carries sequence zero
    a_blank_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_send_valid |-> o_last_result && o_send_sequence == 8'd0)
        else $error("empty result not last or nonzero sequence");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Go-Back-N sender window. Queue, ack, timeout and
// unused-op words go in through the valid/stall port while both sides idle at random.
// A model of the window in this file predicts every result word, and a
// checker compares each one in order, field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int SEQ_SPACE = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_sequence;
        logic       retx;
        logic [1:0] timer_action;
        logic       ack_accepted;
        logic       space_full;
        logic       last_result;
    } t_send_rec;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_operation = gbn_pkg::OP_QUEUE;
    logic [7:0] i_ack_number = 8'd0;
    logic       i_ack_intact = 1'b0;
    logic       i_window_size_we = 1'b0;
    logic [5:0] i_window_size_wdata = 6'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_send_valid;
    logic [7:0] o_send_sequence;
    logic       o_is_retransmission;
    logic [1:0] o_timer_action;
    logic       o_ack_accepted;
    logic       o_space_full_error;
    logic       o_last_result;

    // window model state
    logic [5:0] win_size_reg;
    logic [7:0] win_base;
    logic [7:0] free_seq;
    logic [7:0] unsent_seq;
    logic       timer_on;

    t_send_rec expected_sends[$];
    int error_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    go_back_n_sender_window #(
        .SEQ_SPACE(SEQ_SPACE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_ack_number(i_ack_number),
        .i_ack_intact(i_ack_intact),
        .i_window_size_we(i_window_size_we),
        .i_window_size_wdata(i_window_size_wdata),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_send_valid(o_send_valid),
        .o_send_sequence(o_send_sequence),
        .o_is_retransmission(o_is_retransmission),
        .o_timer_action(o_timer_action),
        .o_ack_accepted(o_ack_accepted),
        .o_space_full_error(o_space_full_error),
        .o_last_result(o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic int seq_gap(logic [7:0] a, logic [7:0] b);
        return (int'(a) + SEQ_SPACE - int'(b)) % SEQ_SPACE;
    endfunction

    function automatic t_send_rec make_rec(logic v, logic [7:0] sq, logic retx, logic acc,
                                           logic err);
        t_send_rec r;
        r = '0;
        r.send_valid = v;
        r.send_sequence = v ? sq : 8'd0;
        r.retx = retx;
        r.ack_accepted = acc;
        r.space_full = err;
        return r;
    endfunction

    // send every queued packet that fits in the window
    function automatic void release_queued(ref t_send_rec batch[$], input logic acc);
        int w;
        w = int'(win_size_reg);
        if (w == 0) w = 1;
        if (w > gbn_pkg::MAX_WINDOW) w = gbn_pkg::MAX_WINDOW;
        if (w > SEQ_SPACE - 1) w = SEQ_SPACE - 1;
        while (batch.size() < gbn_pkg::MAX_WINDOW && unsent_seq != free_seq &&
               seq_gap(unsent_seq, win_base) < w) begin
            batch.push_back(make_rec(1'b1, unsent_seq, 1'b0, acc, 1'b0));
            unsent_seq = 8'((int'(unsent_seq) + 1) % SEQ_SPACE);
        end
    endfunction

    function automatic void predict_window_step(logic [1:0] op, logic [7:0] ack,
                                                logic intact);
        t_send_rec batch[$];
        logic [1:0] tmr;
        logic [7:0] s;
        int flight;
        int d;
        tmr = gbn_pkg::TMR_NONE;
        case (op)
            gbn_pkg::OP_QUEUE: begin
                if (seq_gap(free_seq, win_base) >= SEQ_SPACE - 1) begin
                    batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b1));
                end else begin
                    free_seq = 8'((int'(free_seq) + 1) % SEQ_SPACE);
                    release_queued(batch, 1'b0);
                    if (batch.size() == 0)
                        batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
                    if (!timer_on) begin
                        timer_on = 1'b1;
                        tmr = gbn_pkg::TMR_START;
                    end
                end
            end
            gbn_pkg::OP_ACK: begin
                flight = seq_gap(unsent_seq, win_base);
                d = seq_gap(8'(int'(ack) % SEQ_SPACE), win_base);
                if (!intact) begin
                    if (!timer_on) begin
                        timer_on = 1'b1;
                        tmr = gbn_pkg::TMR_START;
                    end
                    batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
                end else if (int'(ack) >= SEQ_SPACE || d == 0 || d > flight) begin
                    batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
                end else begin
                    win_base = ack;
                    release_queued(batch, 1'b1);
                    if (batch.size() == 0)
                        batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b1, 1'b0));
                    if (free_seq != win_base) begin
                        timer_on = 1'b1;
                        tmr = gbn_pkg::TMR_RESTART;
                    end else begin
                        timer_on = 1'b0;
                        tmr = gbn_pkg::TMR_STOP;
                    end
                end
            end
            gbn_pkg::OP_TIMEOUT: begin
                s = win_base;
                while (batch.size() < gbn_pkg::MAX_WINDOW && s != unsent_seq) begin
                    batch.push_back(make_rec(1'b1, s, 1'b1, 1'b0, 1'b0));
                    s = 8'((int'(s) + 1) % SEQ_SPACE);
                end
                if (batch.size() == 0)
                    batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
                timer_on = 1'b1;
                tmr = gbn_pkg::TMR_START;
            end
            default: begin
                batch.push_back(make_rec(1'b0, 8'd0, 1'b0, 1'b0, 1'b0));
            end
        endcase
        batch[batch.size() - 1].timer_action = tmr;
        batch[batch.size() - 1].last_result = 1'b1;
        foreach (batch[i]) expected_sends.push_back(batch[i]);
    endfunction

    always @(posedge i_clk) begin
        t_send_rec exp_rec;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sends.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                exp_rec = expected_sends.pop_front();
                if (o_send_valid !== exp_rec.send_valid) begin
                    $error("send_valid: expected %0d, got %0d", exp_rec.send_valid,
                           o_send_valid);
                    error_count++;
                end
                if (o_send_sequence !== exp_rec.send_sequence) begin
                    $error("send_sequence: expected %0d, got %0d", exp_rec.send_sequence,
                           o_send_sequence);
                    error_count++;
                end
                if (o_is_retransmission !== exp_rec.retx) begin
                    $error("is_retransmission: expected %0d, got %0d", exp_rec.retx,
                           o_is_retransmission);
                    error_count++;
                end
                if (o_timer_action !== exp_rec.timer_action) begin
                    $error("timer_action: expected %0d, got %0d", exp_rec.timer_action,
                           o_timer_action);
                    error_count++;
                end
                if (o_ack_accepted !== exp_rec.ack_accepted) begin
                    $error("ack_accepted: expected %0d, got %0d", exp_rec.ack_accepted,
                           o_ack_accepted);
                    error_count++;
                end
                if (o_space_full_error !== exp_rec.space_full) begin
                    $error("space_full_error: expected %0d, got %0d", exp_rec.space_full,
                           o_space_full_error);
                    error_count++;
                end
                if (o_last_result !== exp_rec.last_result) begin
                    $error("last_result: expected %0d, got %0d", exp_rec.last_result,
                           o_last_result);
                    error_count++;
                end
            end
        end
    end

    task automatic send_word(logic [1:0] op, logic [7:0] ack, logic intact);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_ack_number <= ack;
        i_ack_intact <= intact;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        predict_window_step(op, ack, intact);
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (expected_sends.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(logic [5:0] w);
        wait_results_done();
        i_window_size_we <= 1'b1;
        i_window_size_wdata <= w;
        @(posedge i_clk);
        i_window_size_we <= 1'b0;
        win_size_reg = w;
    endtask

    task automatic test_directed();
        send_word(gbn_pkg::OP_ACK, 8'd1, 1'b1);      // ack at the base, nothing in flight
        send_word(gbn_pkg::OP_TIMEOUT, 8'd0, 1'b0);  // timeout with nothing in flight
        send_word(gbn_pkg::OP_ACK, 8'd0, 1'b0);      // corrupted ack, timer running
        repeat (3) send_word(gbn_pkg::OP_QUEUE, 8'd0, 1'b0);
        send_word(gbn_pkg::OP_ACK, 8'd200, 1'b1);    // past the flight
        send_word(gbn_pkg::OP_ACK, 8'd3, 1'b1);
        send_word(gbn_pkg::OP_TIMEOUT, 8'd255, 1'b1);
        send_word(gbn_pkg::OP_ACK, 8'd4, 1'b1);      // everything acked, stop the timer
        send_word(gbn_pkg::OP_ACK, 8'd255, 1'b0);    // corrupted ack, timer stopped
        send_word(OP_UNUSED, 8'd255, 1'b1);
        repeat (11) send_word(gbn_pkg::OP_QUEUE, 8'd255, 1'b1);
        send_word(gbn_pkg::OP_ACK, 8'd9, 1'b1);
        send_word(gbn_pkg::OP_TIMEOUT, 8'd0, 1'b0);
    endtask

    task automatic test_window_extremes();
        set_window(6'd0);
        repeat (3) send_word(gbn_pkg::OP_QUEUE, 8'd0, 1'b0);
        send_word(gbn_pkg::OP_ACK, 8'((int'(win_base) + 1) % SEQ_SPACE), 1'b1);
        set_window(6'd63);
        repeat (34) send_word(gbn_pkg::OP_QUEUE, 8'd0, 1'b0);
        send_word(gbn_pkg::OP_TIMEOUT, 8'd0, 1'b0);
        send_word(gbn_pkg::OP_ACK, unsent_seq, 1'b1);
        send_word(gbn_pkg::OP_ACK, unsent_seq, 1'b1);
    endtask

    task automatic random_word(output bit counted);
        int r;
        int flight;
        r = $urandom_range(0, 99);
        flight = seq_gap(unsent_seq, win_base);
        counted = 1'b1;
        if (r < 45) begin
            send_word(gbn_pkg::OP_QUEUE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else if (r < 75 && flight > 0) begin
            send_word(gbn_pkg::OP_ACK,
                      8'((int'(win_base) + int'($urandom_range(1, flight))) % SEQ_SPACE),
                      1'b1);
        end else if (r < 85) begin
            send_word(gbn_pkg::OP_TIMEOUT, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end else if (r < 92) begin
            send_word(gbn_pkg::OP_ACK, 8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 97) begin
            send_word(gbn_pkg::OP_ACK, 8'($urandom_range(0, 255)), 1'b1);
            counted = 1'b0;
        end else begin
            send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            counted = 1'b0;
        end
    endtask

    task automatic test_random_traffic(int idle, int stall, logic [5:0] win_a,
                                       logic [5:0] win_b);
        logic [5:0] wins[2];
        int got;
        bit counted;
        wins[0] = win_a;
        wins[1] = win_b;
        idle_pct = idle;
        stall_pct = stall;
        for (int p = 0; p < 2; p++) begin
            set_window(wins[p]);
            got = 0;
            while (got < 5) begin
                random_word(counted);
                if (counted) got++;
            end
        end
    endtask

    // fill the sequence space without acks, overflow it, then ack it all away
    task automatic test_space_full();
        int n;
        n = 0;
        idle_pct = 0;
        stall_pct = 0;
        set_window(6'd32);
        while (seq_gap(free_seq, win_base) < SEQ_SPACE - 1) begin
            send_word(gbn_pkg::OP_QUEUE, 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
            n++;
            if (n % 64 == 0) send_word(gbn_pkg::OP_TIMEOUT, 8'd0, 1'b0);
        end
        repeat (2) send_word(gbn_pkg::OP_QUEUE, 8'd0, 1'b0);
        send_word(gbn_pkg::OP_ACK, 8'd0, 1'b0);
        while (win_base != free_seq) send_word(gbn_pkg::OP_ACK, unsent_seq, 1'b1);
    endtask

    initial begin
        win_size_reg = gbn_pkg::WIN_RESET;
        win_base = 8'd1;
        free_seq = 8'd1;
        unsent_seq = 8'd1;
        timer_on = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_window_extremes();
        test_random_traffic(0, 0, 6'd1, 6'd63);
        test_random_traffic(56, 0, 6'd0, 6'd32);
        test_random_traffic(0, 56, 6'd7, 6'($urandom_range(0, 63)));
        test_random_traffic(26, 26, 6'd20, 6'd10);
        test_space_full();
        test_random_traffic(26, 26, 6'd3, 6'd10);

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_sends.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gbn_pkg.sv
hw/rtl/gbn_ctrl.sv
hw/rtl/gbn_dp.sv
hw/rtl/go_back_n_sender_window.sv
hw/rtl/gbn_checker.sv
tb/sv/tb.sv
